[hdl/ss_pkg.sv]
package ss_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SOURCE = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // Character constants
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // Per-cycle control broadcast along the cell row
  typedef struct packed {
    logic shift;  // source byte steps the match bits
    logic clear;  // restart of the search drops all match bits
  } ss_ctrl_t;

  // ASCII upper-to-lower fold when ignore_case is set
  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    logic [7:0] r;
    r = c;
    if (ic && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

[hdl/ss_cell.sv]
module ss_cell (
  input  logic             clk,
  input  logic             rst,
  input  ss_pkg::ss_ctrl_t ctrl,
  input  logic             load,
  input  logic [7:0]       load_byte,
  input  logic             active,
  input  logic             ignore_case,
  input  logic [7:0]       src_folded,
  input  logic             prev_hit,
  output logic             hit,
  output logic             hit_next
);
  import ss_pkg::*;

  logic [7:0] pat;

  // Partial match extends if the neighbor matched up to here and this byte agrees
  assign hit_next = prev_hit && active && (fold(pat, ignore_case) == src_folded);

  // Pattern byte, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      pat <= load_byte;
    end
  end

  // Match bit
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.clear) begin
      hit <= 1'b0;
    end else if (ctrl.shift) begin
      hit <= hit_next;
    end
  end

endmodule

[hdl/substring_search.sv]
// Channel   Handshake              Payload
// input     in_valid / in_stall    operation[1:0], data_byte[7:0]
// output    out_valid / out_stall  found, position[15:0]
// config    cfg_valid / cfg_ready  cfg_ignore_case
//
// One item is taken every cycle while in_stall is low; the row of pattern cells updates all
// match bits in parallel in the cycle the item is accepted.
// A result shows in the output register in the cycle after its item.
// in_stall is high only while a result is held and out_stall is high.
// Reset is synchronous and clears count, match bits, index and output valid;
// pattern bytes are not cleared and there is no clearing pass.
module substring_search #(
  parameter int PATTERN_MAX    = 16,
  parameter int POSITION_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [15:0] position,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_ignore_case
);
  import ss_pkg::*;

  localparam int CW = $clog2(PATTERN_MAX + 1);
  localparam int PW = POSITION_WIDTH;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  logic          ignore_case;
  logic [CW-1:0] count;
  logic [PW-1:0] idx;
  logic          answered;

  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX-1:0] hit_next;
  logic [PATTERN_MAX-1:0] active;
  logic [PATTERN_MAX-1:0] is_last;
  logic [PATTERN_MAX-1:0] load;

  op_t        op;
  logic       accept;
  logic       is_source;
  logic       is_end;
  logic       do_append;
  logic       do_shift;
  logic       restart;
  logic       match;
  logic [7:0] src_folded;
  ss_ctrl_t   ctrl;

  logic          emit;
  logic          emit_found;
  logic [PW-1:0] emit_pos;
  logic [PW-1:0] match_pos;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_case <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      ignore_case <= cfg_ignore_case;
    end
  end

  // Item decode
  assign op         = op_t'(operation);
  assign in_stall   = out_valid && out_stall;
  assign accept     = in_valid && !in_stall;
  assign is_source  = (op == OP_SOURCE) && (data_byte != CHAR_NUL);
  assign is_end     = (op == OP_END) || ((op == OP_SOURCE) && (data_byte == CHAR_NUL));
  assign do_append  = (op == OP_APPEND) && (data_byte != CHAR_NUL)
                      && (count < CW'(PATTERN_MAX));
  assign do_shift   = accept && is_source && !answered && (count != '0);
  assign restart    = accept && ((op == OP_CLEAR) || (op == OP_APPEND) || is_end);
  assign src_folded = fold(data_byte, ignore_case);
  assign ctrl.shift = do_shift;
  assign ctrl.clear = restart;

  // Cell row
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    assign active[i]  = CW'(i) < count;
    assign is_last[i] = count == CW'(i + 1);
    assign load[i]    = accept && do_append && (count == CW'(i));

    ss_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .load        (load[i]),
      .load_byte   (data_byte),
      .active      (active[i]),
      .ignore_case (ignore_case),
      .src_folded  (src_folded),
      .prev_hit    (i == 0 ? 1'b1 : hit[(i == 0 ? 0 : i - 1)]),
      .hit         (hit[i]),
      .hit_next    (hit_next[i])
    );
  end

  // Full-pattern match comes from the cell at the pattern's end
  assign match     = |(hit_next & is_last);
  assign match_pos = (idx == POS_MAX) ? POS_MAX : idx - PW'(count - CW'(1));

  // Result selection
  always_comb begin
    emit       = 1'b0;
    emit_found = 1'b0;
    emit_pos   = '0;
    if (accept) begin
      if (is_end) begin
        emit       = !answered;
        emit_found = (count == '0);
      end else if (is_source && !answered) begin
        if (count == '0) begin
          emit       = 1'b1;
          emit_found = 1'b1;
        end else if (match) begin
          emit       = 1'b1;
          emit_found = 1'b1;
          emit_pos   = match_pos;
        end
      end
    end
  end

  // Search state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx      <= '0;
      answered <= 1'b0;
    end else if (accept) begin
      if (op == OP_CLEAR) begin
        count <= '0;
      end else if (do_append) begin
        count <= count + CW'(1);
      end
      if (restart) begin
        idx      <= '0;
        answered <= 1'b0;
      end else if (is_source && !answered) begin
        if (emit) begin
          answered <= 1'b1;
        end
        if (do_shift && idx != POS_MAX) begin
          idx <= idx + PW'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found    <= emit_found;
      position <= 16'(emit_pos);
    end
  end

  // Checks
  a_notfound_pos : assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> position == 16'd0)
    else $error("not-found result with nonzero position");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(PATTERN_MAX))
    else $error("pattern count beyond capacity");

  a_idle_cells : assert property (@(posedge clk) disable iff (rst)
    (hit & ~active) == '0)
    else $error("match bit set beyond pattern end");

endmodule
